/* hw/rtl/ipv4hp_pkg.sv */
// Package with the types, character codes and reset state of the IPv4 host string parser.
package ipv4hp_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned UPPER_W = 24;
  localparam int unsigned COUNT_W = 3;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [ADDR_W-1:0] MIDDLE_MAX = 32'd255;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef struct packed {
    logic               failed;
    logic [ADDR_W-1:0]  part_value;
    logic               part_overflow;
    radix_t             part_radix;
    logic [1:0]         part_position;
    logic               part_starts_zero;
    logic               prev_was_digit;
    logic               prev_was_x;
    logic [1:0]         dots_seen;
    logic [UPPER_W-1:0] upper_parts;
  } parse_state_t;

  typedef struct packed {
    logic               valid_res;
    logic [ADDR_W-1:0]  address;
    logic [COUNT_W-1:0] part_count;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    failed:           1'b0,
    part_value:       '0,
    part_overflow:    1'b0,
    part_radix:       RADIX_DEC,
    part_position:    2'd0,
    part_starts_zero: 1'b0,
    prev_was_digit:   1'b0,
    prev_was_x:       1'b0,
    dots_seen:        2'd0,
    upper_parts:      '0
  };

endpackage

/* hw/rtl/ipv4hp_step.sv */
// Next-state and result logic for one character of the IPv4 host string parser.
module ipv4hp_step
  import ipv4hp_pkg::*;
(
  input  parse_state_t  st,
  input  logic [7:0]    char_code,
  input  logic          is_last,
  output parse_state_t  st_nxt,
  output parse_result_t res
);

  radix_t            rad;
  logic              is_num;
  logic              is_lo_hex;
  logic              is_up_hex;
  logic              is_x;
  logic              digit_ok;
  logic [3:0]        digit;
  logic [35:0]       prod;
  logic [36:0]       acc_sum;
  logic [ADDR_W-1:0] bound;
  logic              ok_final;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    is_num    = (char_code >= CH_0) && (char_code <= CH_9);
    is_lo_hex = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
    is_up_hex = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
    is_x      = (char_code == CH_LO_X) || (char_code == CH_UP_X);

    rad = st.part_radix;
    if ((st.part_position == 2'd1) && st.part_starts_zero && (rad == RADIX_DEC)) begin
      rad = RADIX_OCT;
    end

    digit    = is_num ? char_code[3:0] : 4'(char_code[3:0] + 4'd9);
    digit_ok = 1'b0;
    if (is_num) begin
      digit_ok = !(char_code[3] && (rad == RADIX_OCT));
    end else if (is_lo_hex || is_up_hex) begin
      digit_ok = (rad == RADIX_HEX);
    end

    case (rad)
      RADIX_HEX: prod = {st.part_value, 4'b0000};
      RADIX_OCT: prod = {1'b0, st.part_value, 3'b000};
      default:   prod = {1'b0, st.part_value, 3'b000} + {3'b000, st.part_value, 1'b0};
    endcase
    acc_sum = {1'b0, prod} + {33'd0, digit};

    st_nxt = st;
    if (!st.failed) begin
      if (char_code == CH_DOT) begin
        if (is_last) begin
          if (!st.prev_was_digit) begin
            st_nxt.failed = 1'b1;
          end
        end else if (!(st.prev_was_digit || st.prev_was_x) || (st.dots_seen == 2'd3)) begin
          st_nxt.failed = 1'b1;
        end else if (st.part_overflow || (st.part_value > MIDDLE_MAX)) begin
          st_nxt.failed = 1'b1;
        end else begin
          st_nxt.upper_parts      = {st.upper_parts[15:0], st.part_value[7:0]};
          st_nxt.dots_seen        = 2'(st.dots_seen + 2'd1);
          st_nxt.part_value       = '0;
          st_nxt.part_overflow    = 1'b0;
          st_nxt.part_radix       = RADIX_DEC;
          st_nxt.part_position    = 2'd0;
          st_nxt.part_starts_zero = 1'b0;
          st_nxt.prev_was_digit   = 1'b0;
          st_nxt.prev_was_x       = 1'b0;
        end
      end else begin
        st_nxt.part_radix = rad;
        if (is_x) begin
          if (!st.prev_was_digit || is_last || (st.part_position != 2'd1) ||
              !st.part_starts_zero) begin
            st_nxt.failed = 1'b1;
          end else begin
            st_nxt.part_radix     = RADIX_HEX;
            st_nxt.prev_was_digit = 1'b0;
            st_nxt.prev_was_x     = 1'b1;
          end
        end else if (!digit_ok) begin
          st_nxt.failed = 1'b1;
        end else begin
          if ((st.part_position == 2'd0) && (char_code == CH_0)) begin
            st_nxt.part_starts_zero = 1'b1;
          end
          if (|acc_sum[36:32]) begin
            st_nxt.part_overflow = 1'b1;
            st_nxt.part_value    = '1;
          end else begin
            st_nxt.part_value = acc_sum[31:0];
          end
          st_nxt.prev_was_digit = 1'b1;
          st_nxt.prev_was_x     = 1'b0;
        end
        if (!st_nxt.failed && (st.part_position != 2'd3)) begin
          st_nxt.part_position = 2'(st.part_position + 2'd1);
        end
      end
    end

    bound    = 32'hFFFF_FFFF >> {st_nxt.dots_seen, 3'b000};
    ok_final = !st_nxt.failed && !st_nxt.part_overflow && (st_nxt.part_value <= bound);
    case (st_nxt.dots_seen)
      2'd1:    addr = {st_nxt.upper_parts[7:0], 24'd0} | st_nxt.part_value;
      2'd2:    addr = {st_nxt.upper_parts[15:0], 16'd0} | st_nxt.part_value;
      2'd3:    addr = {st_nxt.upper_parts[23:0], 8'd0} | st_nxt.part_value;
      default: addr = st_nxt.part_value;
    endcase

    res.valid_res  = ok_final;
    res.address    = ok_final ? addr : '0;
    res.part_count = 3'({1'b0, st_nxt.dots_seen} + 3'd1);

    if (is_last) begin
      st_nxt = STATE_RESET;
    end
  end

endmodule

/* hw/rtl/ipv4_host_string_parser.sv */
// Top level of the IPv4 host string parser: parse state, result register and handshakes.
//
//   Channel   Direction  Handshake             Word contents
//   in_       input      in_valid / in_ready   char_code, is_last
//   out_      output     out_valid / out_ready valid_res, address, part_count
//
// One character is taken every cycle while in_ready is high; the running parse
// state updates in the cycle it is accepted. A string's result appears in the
// output register in the cycle after its last character is accepted. A waiting
// result stalls the input only when out_ready is low, since the register is
// reloaded as it drains. Synchronous reset clears the parse state and output valid.
module ipv4_host_string_parser
  import ipv4hp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_valid_res,
  output logic [ADDR_W-1:0]  out_address,
  output logic [COUNT_W-1:0] out_part_count
);

  parse_state_t  state_r;
  parse_state_t  state_nxt;
  parse_result_t res_nxt;
  parse_result_t res_r;
  logic          out_valid_r;
  logic          in_fire;

  ipv4hp_step u_step (
    .st        (state_r),
    .char_code (in_char_code),
    .is_last   (in_is_last),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (in_fire && in_is_last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_is_last) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = res_r.valid_res;
  assign out_address    = res_r.address;
  assign out_part_count = res_r.part_count;

endmodule
